// ===== hdl/bicz_pkg.sv =====
// Shared types, codes and kernel coefficient function for the bicubic image zoom block.
`timescale 1ns / 1ps
package bicz_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_DIVA,
		ST_DIVQ,
		ST_DIVT,
		ST_WGT,
		ST_WCAP,
		ST_PIX,
		ST_FIN,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		MAC_LOAD,
		MAC_ADD,
		MAC_TOT,
		MAC_TSET
	} mac_mode_t;

	typedef struct packed {
		logic      en;
		mac_mode_t mode;
		logic      shift;
	} mac_cmd_t;

	localparam logic [2:0] REG_RATIO_NUM     = 3'd0;
	localparam logic [2:0] REG_RATIO_DEN     = 3'd1;
	localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd2;
	localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_TARGET_WIDTH  = 3'd4;
	localparam logic [2:0] REG_TARGET_HEIGHT = 3'd5;
	localparam logic [2:0] REG_KERNEL_SHAPE  = 3'd6;

	localparam logic signed [17:0] K_ONE   = 18'sd4096;
	localparam logic signed [17:0] K_TWO   = 18'sd8192;
	localparam logic signed [17:0] K_THREE = 18'sd12288;

	localparam logic signed [63:0] WEIGHT_ROUND = 64'sd1 <<< 39;
	localparam logic signed [63:0] TOT_INIT     = 64'sd1 <<< 27;

	// Coefficient of t^power for the weight of one tap (tap 0 is base-1).
	function automatic logic signed [17:0] kernel_coef(input logic signed [13:0] a,
		input logic [1:0] tap, input logic [1:0] power);
		logic signed [17:0] a18;
		logic signed [17:0] r;
		a18 = 18'(a);
		r = '0;
		case (tap)
			2'd0: begin
				case (power)
					2'd3: r = a18;
					2'd2: r = -(a18 <<< 1);
					2'd1: r = a18;
					default: r = '0;
				endcase
			end
			2'd1: begin
				case (power)
					2'd3: r = a18 + K_TWO;
					2'd2: r = -(a18 + K_THREE);
					2'd1: r = '0;
					default: r = K_ONE;
				endcase
			end
			2'd2: begin
				case (power)
					2'd3: r = -(a18 + K_TWO);
					2'd2: r = (a18 <<< 1) + K_THREE;
					2'd1: r = -a18;
					default: r = '0;
				endcase
			end
			default: begin
				case (power)
					2'd3: r = -a18;
					2'd2: r = a18;
					default: r = '0;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/bicz_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bicz_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/bicz_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module bicz_div import bicz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [13:0] num,
	input  logic [13:0] rem_init,
	input  logic [23:0] dividend,
	input  logic [4:0]  steps,
	output logic        busy,
	output logic [23:0] quo,
	output logic [13:0] rem
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [13:0] rem_q;
	logic [13:0] dsr_q;
	logic [23:0] quo_q;
	logic [14:0] shifted;
	logic [14:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[23]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= dividend;
			dsr_q <= (num == 14'd0) ? 14'd1 : num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[13:0] : shifted[13:0];
			quo_q <= {quo_q[22:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// ===== hdl/bicz_mac.sv =====
// Shared multiply-accumulate unit with a registered product and two accumulators.
`timescale 1ns / 1ps
module bicz_mac import bicz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_cmd_t           cmd,
	input  logic signed [35:0] op_a,
	input  logic signed [17:0] op_b,
	input  logic signed [63:0] op_c,
	output logic signed [63:0] acc,
	output logic signed [63:0] tot
);
	mac_cmd_t           cmd_s1;
	logic signed [53:0] prod;
	logic signed [63:0] prod_s1;
	logic signed [63:0] c_s1;
	logic signed [63:0] acc_q;
	logic signed [63:0] tot_q;

	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= cmd.shift ? (64'(prod) <<< 24) : 64'(prod);
		c_s1    <= op_c;
		if (cmd_s1.en) begin
			case (cmd_s1.mode)
				MAC_LOAD: acc_q <= c_s1 + prod_s1;
				MAC_ADD:  acc_q <= acc_q + prod_s1;
				MAC_TOT:  tot_q <= tot_q + prod_s1;
				MAC_TSET: tot_q <= c_s1;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	assign acc = acc_q;
	assign tot = tot_q;
endmodule

// ===== hdl/bicubic_image_zoom.sv =====
// Top level of the bicubic image zoom block: configuration, sequencer and frame store.
//
// Input beats arrive on the s_ channel. With s_tuser low a beat stores one source pixel
// into the frame store when it fits and gives no result. With s_tuser high a beat
// requests one output pixel; exactly one result beat then leaves on the m_ channel.
// A request beyond the target size returns with m_tuser set and value 0, uncomputed.
// Any other request is computed in order: per axis one product, a bit-serial division
// for the integer part and one for the fraction, and four weight polynomials of four
// steps each, then sixteen pixel products and four column products; the products run
// on the single multiply-accumulate unit and the divisions on the bit-serial divider.
// s_tready is high only while the sequencer is idle, so one item is worked on at a time.
// The result waits in an output register; a stalled receiver holds it and delays the
// next request only when a new result is ready to replace it.
// Configuration writes are taken on any cycle with cfg_wr_en high and must be made
// while the block is idle. Reset loads the register defaults and empties the output;
// the frame store content is undefined until written.
`timescale 1ns / 1ps
module bicubic_image_zoom import bicz_pkg::*; #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int MAX_OUT_DIM    = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // row[9:0], col[19:10], pixel[35:20], zero fill
	input  logic [0:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // value
	output logic [0:0]  m_tuser,   // out_of_range
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data
);
	localparam int RW    = $clog2(MAX_SRC_HEIGHT);
	localparam int CW    = $clog2(MAX_SRC_WIDTH);
	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [13:0]        num_q, den_q;
	logic [8:0]         src_w_q, src_h_q;
	logic [10:0]        tgt_w_q, tgt_h_q;
	logic signed [13:0] shape_q;

	seq_state_t state_q, state_d;
	logic       ph_q, ph_d;
	logic       axis_q, axis_d;
	logic [1:0] widx_q, widx_d;
	logic [1:0] wstep_q, wstep_d;
	logic [2:0] ltap_q, ltap_d;
	logic [1:0] mtap_q, mtap_d;
	logic       out_valid_q, out_valid_d;

	logic [9:0]         req_row_q, req_col_q;
	logic [23:0]        rbase_q, rbase_d, cbase_q, cbase_d;
	logic [13:0]        t_q, t_d;
	logic signed [47:0] h2_q, h2_d;
	logic signed [15:0] wr_q [4];
	logic signed [15:0] wr_d [4];
	logic signed [15:0] wc_q [4];
	logic signed [15:0] wc_d [4];
	logic [7:0]         res_value_q, res_value_d, out_value_q, out_value_d;
	logic               res_oor_q, res_oor_d, out_oor_q, out_oor_d;

	logic        accept;
	logic        in_op;
	logic [9:0]  in_row, in_col;
	logic [15:0] in_pix;
	logic        in_oor;
	logic        wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [15:0] ram_rdata;
	logic [9:0]  coord;

	logic [24:0] sr, sc;
	logic        row_ok, col_ok;
	logic signed [23:0] wq;
	logic signed [15:0] wsat;

	mac_cmd_t           cmd;
	logic signed [35:0] op_a;
	logic signed [17:0] op_b;
	logic signed [63:0] op_c;
	logic signed [63:0] acc, tot;

	logic        div_start, div_busy;
	logic [13:0] div_rem_init, div_rem;
	logic [23:0] div_dividend, div_quo;
	logic [4:0]  div_steps;

	assign in_op  = s_tuser[0];
	assign in_row = s_tdata[9:0];
	assign in_col = s_tdata[19:10];
	assign in_pix = s_tdata[35:20];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign in_oor = (11'(in_row) >= tgt_h_q) || (11'(in_col) >= tgt_w_q) ||
		(32'(in_row) >= MAX_OUT_DIM) || (32'(in_col) >= MAX_OUT_DIM);

	assign wr_en   = accept && !in_op && (32'(in_row) < MAX_SRC_HEIGHT) &&
		(32'(in_col) < MAX_SRC_WIDTH);
	assign wr_addr = AW'(AW'(RW'(in_row)) * AW'(MAX_SRC_WIDTH)) + AW'(CW'(in_col));

	assign sr = 25'(rbase_q) + 25'(ltap_q[1:0]);
	assign sc = 25'(cbase_q) + 25'(mtap_q);
	assign row_ok = (sr != 25'd0) && (sr <= 25'(src_h_q)) && (32'(sr) <= MAX_SRC_HEIGHT);
	assign col_ok = (sc != 25'd0) && (sc <= 25'(src_w_q)) && (32'(sc) <= MAX_SRC_WIDTH);
	assign rd_addr = AW'(AW'(RW'(sr - 25'd1)) * AW'(MAX_SRC_WIDTH)) + AW'(CW'(sc - 25'd1));

	assign coord = axis_q ? req_col_q : req_row_q;

	assign wq   = acc[63:40];
	assign wsat = (wq > 24'sd32767) ? 16'sh7FFF :
		(wq < -24'sd32768) ? 16'sh8000 : wq[15:0];

	bicz_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(in_pix),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	bicz_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (num_q),
		.rem_init(div_rem_init),
		.dividend(div_dividend),
		.steps   (div_steps),
		.busy    (div_busy),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	bicz_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.op_a  (op_a),
		.op_b  (op_b),
		.op_c  (op_c),
		.acc   (acc),
		.tot   (tot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q   <= 14'd1;
			den_q   <= 14'd1;
			src_w_q <= 9'd256;
			src_h_q <= 9'd256;
			tgt_w_q <= 11'd256;
			tgt_h_q <= 11'd256;
			shape_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RATIO_NUM:     num_q   <= cfg_data;
				REG_RATIO_DEN:     den_q   <= cfg_data;
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data[8:0];
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data[8:0];
				REG_TARGET_WIDTH:  tgt_w_q <= cfg_data[10:0];
				REG_TARGET_HEIGHT: tgt_h_q <= cfg_data[10:0];
				REG_KERNEL_SHAPE:  shape_q <= cfg_data;
				default:           num_q   <= num_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= 1'b0;
			axis_q      <= 1'b0;
			widx_q      <= '0;
			wstep_q     <= '0;
			ltap_q      <= '0;
			mtap_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ph_q        <= ph_d;
			axis_q      <= axis_d;
			widx_q      <= widx_d;
			wstep_q     <= wstep_d;
			ltap_q      <= ltap_d;
			mtap_q      <= mtap_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_row_q <= in_row;
			req_col_q <= in_col;
		end
		rbase_q     <= rbase_d;
		cbase_q     <= cbase_d;
		t_q         <= t_d;
		h2_q        <= h2_d;
		wr_q        <= wr_d;
		wc_q        <= wc_d;
		res_value_q <= res_value_d;
		res_oor_q   <= res_oor_d;
		out_value_q <= out_value_d;
		out_oor_q   <= out_oor_d;
	end

	always_comb begin
		state_d      = state_q;
		ph_d         = ph_q;
		axis_d       = axis_q;
		widx_d       = widx_q;
		wstep_d      = wstep_q;
		ltap_d       = ltap_q;
		mtap_d       = mtap_q;
		out_valid_d  = out_valid_q;
		rbase_d      = rbase_q;
		cbase_d      = cbase_q;
		t_d          = t_q;
		h2_d         = h2_q;
		wr_d         = wr_q;
		wc_d         = wc_q;
		res_value_d  = res_value_q;
		res_oor_d    = res_oor_q;
		out_value_d  = out_value_q;
		out_oor_d    = out_oor_q;
		cmd          = '0;
		op_a         = '0;
		op_b         = '0;
		op_c         = '0;
		div_start    = 1'b0;
		div_rem_init = '0;
		div_dividend = '0;
		div_steps    = '0;

		if (m_tvalid && m_tready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (accept && in_op) begin
					if (in_oor) begin
						res_value_d = '0;
						res_oor_d   = 1'b1;
						state_d     = ST_EMIT;
					end else begin
						axis_d  = 1'b0;
						ph_d    = 1'b0;
						state_d = ST_PROD;
					end
				end
			end
			ST_PROD: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					cmd.en   = 1'b1;
					cmd.mode = MAC_LOAD;
					op_a     = 36'(coord);
					op_b     = 18'(den_q);
					state_d  = ST_DIVA;
				end
			end
			ST_DIVA: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					div_start    = 1'b1;
					div_dividend = acc[23:0];
					div_steps    = 5'd24;
					state_d      = ST_DIVQ;
				end
			end
			ST_DIVQ: begin
				if (!div_busy) begin
					if (axis_q) begin
						cbase_d = div_quo;
					end else begin
						rbase_d = div_quo;
					end
					div_start    = 1'b1;
					div_rem_init = div_rem;
					div_steps    = 5'd14;
					state_d      = ST_DIVT;
				end
			end
			ST_DIVT: begin
				if (!div_busy) begin
					t_d     = div_quo[13:0];
					widx_d  = '0;
					wstep_d = '0;
					ph_d    = 1'b0;
					state_d = ST_WGT;
				end
			end
			ST_WGT: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					cmd.en   = 1'b1;
					cmd.mode = MAC_LOAD;
					op_b     = 18'(t_q);
					case (wstep_q)
						2'd0: begin
							op_a = 36'(kernel_coef(shape_q, widx_q, 2'd3));
							op_c = 64'(kernel_coef(shape_q, widx_q, 2'd2)) <<< 14;
						end
						2'd1: begin
							op_a = acc[35:0];
							op_c = 64'(kernel_coef(shape_q, widx_q, 2'd1)) <<< 28;
						end
						2'd2: begin
							h2_d = acc[47:0];
							op_a = 36'(acc[23:0]);
							op_c = (64'(kernel_coef(shape_q, widx_q, 2'd0)) <<< 42) +
								WEIGHT_ROUND;
						end
						default: begin
							cmd.mode  = MAC_ADD;
							cmd.shift = 1'b1;
							op_a      = 36'($signed(h2_q[47:24]));
							state_d   = ST_WCAP;
						end
					endcase
					wstep_d = wstep_q + 2'd1;
				end
			end
			ST_WCAP: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					if (axis_q) begin
						wc_d[widx_q] = wsat;
					end else begin
						wr_d[widx_q] = wsat;
					end
					widx_d  = widx_q + 2'd1;
					wstep_d = '0;
					if (widx_q == 2'd3) begin
						if (axis_q) begin
							ltap_d  = '0;
							mtap_d  = '0;
							state_d = ST_PIX;
						end else begin
							axis_d  = 1'b1;
							state_d = ST_PROD;
						end
					end else begin
						state_d = ST_WGT;
					end
				end
			end
			ST_PIX: begin
				ph_d = ~ph_q;
				if (!ph_q) begin
					if (ltap_q == 3'd0 && mtap_q == 2'd0) begin
						cmd.en   = 1'b1;
						cmd.mode = MAC_TSET;
						op_c     = TOT_INIT;
					end
				end else if (ltap_q != 3'd4) begin
					cmd.en   = 1'b1;
					cmd.mode = (ltap_q == 3'd0) ? MAC_LOAD : MAC_ADD;
					op_a     = (row_ok && col_ok) ? 36'($signed(ram_rdata)) : '0;
					op_b     = 18'(wr_q[ltap_q[1:0]]);
					ltap_d   = ltap_q + 3'd1;
				end else begin
					cmd.en   = 1'b1;
					cmd.mode = MAC_TOT;
					op_a     = acc[35:0];
					op_b     = 18'(wc_q[mtap_q]);
					ltap_d   = '0;
					mtap_d   = mtap_q + 2'd1;
					if (mtap_q == 2'd3) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				ph_d = ~ph_q;
				if (ph_q) begin
					if (tot[63]) begin
						res_value_d = '0;
					end else if (tot[62:36] != '0) begin
						res_value_d = 8'hFF;
					end else begin
						res_value_d = tot[35:28];
					end
					res_oor_d = 1'b0;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					out_valid_d = 1'b1;
					out_value_d = res_value_q;
					out_oor_d   = res_oor_q;
					ph_d        = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_value_q;
	assign m_tuser[0] = out_oor_q;
endmodule
